### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define MLI_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("interlock assertion failed");

// property checked in every cycle, reset included
`define MLI_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("interlock assertion failed");

`endif

### hdl/mli_pkg.sv
// ---------------------------------------------------------------------------
// mli_pkg
// types, codes and constants shared by the motion lease interlock
// ---------------------------------------------------------------------------
package mli_pkg;

  localparam int TIME_BITS_DEF   = 48;
  localparam int OWNER_BITS_DEF  = 4;

  localparam int KIND_BITS       = 3;
  localparam int SESSION_BITS    = 32;
  localparam int SEQ_BITS        = 32;
  localparam int LEASE_MS_BITS   = 16;
  localparam int LEASE_US_BITS   = 26;
  localparam int FB_TIMEOUT_BITS = 24;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 24;

  localparam logic [LEASE_MS_BITS-1:0]   LEASE_MS_RESET   = 16'd500;
  localparam logic [FB_TIMEOUT_BITS-1:0] FB_TIMEOUT_RESET = 24'd1500000;
  localparam logic [9:0]                 US_PER_MS        = 10'd1000;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_ACQUIRE  = 3'd0,
    KIND_RENEW    = 3'd1,
    KIND_LOCK     = 3'd2,
    KIND_FEEDBACK = 3'd3,
    KIND_CHECK    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_ARG   = 2'd1,
    STATUS_BAD_STATE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_LEASE    = 2'd1,
    CAUSE_FEEDBACK = 2'd2
  } cause_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LEASE_MS   = 2'd0,
    CFG_FB_TIMEOUT = 2'd1
  } cfg_index_t;

  // owner-independent part of one result
  typedef struct packed {
    status_t                  status;
    logic [SESSION_BITS-1:0]  session;
    logic                     allowed;
    cause_t                   cause;
    logic                     lock_changed;
  } res_t;

  function automatic logic [LEASE_US_BITS-1:0] lease_to_us(
    input logic [LEASE_MS_BITS-1:0] ms
  );
    logic [LEASE_US_BITS-1:0] r;
    r = {{(LEASE_US_BITS-LEASE_MS_BITS){1'b0}}, ms} *
        {{(LEASE_US_BITS-10){1'b0}}, US_PER_MS};
    return r;
  endfunction

endpackage

### hdl/motion_lease_interlock.sv
// ---------------------------------------------------------------------------
// motion_lease_interlock
// ownership lease and feedback freshness interlock for motion commands
// ---------------------------------------------------------------------------
// Every accepted item gives exactly one result, through the input register and
// then the result register; one item per cycle is sustained while the output
// side takes each result, the limit being the single decision stage that reads
// and updates the lease state in the same cycle, so each item sees everything
// earlier items left. The input side takes a transfer while a result waits in
// the output register only while the input register is empty. Configuration writes
// are taken in any cycle and belong to idle periods; the lease length is
// turned into microseconds when it is written.
module motion_lease_interlock
  import mli_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int OWNER_BITS = OWNER_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  // item channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [KIND_BITS-1:0]      kind,
  input  logic [OWNER_BITS-1:0]     requester,
  input  logic [SESSION_BITS-1:0]   session_in,
  input  logic [SEQ_BITS-1:0]       sequence_in,
  input  logic [TIME_BITS-1:0]      timestamp,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                status,
  output logic [SESSION_BITS-1:0]   session_out,
  output logic                      allowed,
  output logic [OWNER_BITS-1:0]     owner_out,
  output logic [1:0]                expiry_cause,
  output logic                      lock_changed
);

  // input register
  logic                     in_full;
  logic [KIND_BITS-1:0]     kind_q;
  logic [OWNER_BITS-1:0]    requester_q;
  logic [SESSION_BITS-1:0]  session_q;
  logic [SEQ_BITS-1:0]      sequence_q;
  logic [TIME_BITS-1:0]     timestamp_q;

  logic [LEASE_US_BITS-1:0]   lease_us;
  logic [FB_TIMEOUT_BITS-1:0] fb_timeout;

  res_t                     res;
  logic [OWNER_BITS-1:0]    res_owner;
  logic                     advance;

  // registers never push back
  assign cfg_ready = 1'b1;

  // decision stage moves when it holds an item and the result slot frees up
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  mli_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .lease_us   (lease_us),
    .fb_timeout (fb_timeout)
  );

  mli_core #(
    .TIME_BITS  (TIME_BITS),
    .OWNER_BITS (OWNER_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .kind        (kind_q),
    .requester   (requester_q),
    .session_in  (session_q),
    .sequence_in (sequence_q),
    .timestamp   (timestamp_q),
    .lease_us    (lease_us),
    .fb_timeout  (fb_timeout),
    .res         (res),
    .res_owner   (res_owner)
  );

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  // input register payload, loaded on each transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_q      <= kind;
      requester_q <= requester;
      session_q   <= session_in;
      sequence_q  <= sequence_in;
      timestamp_q <= timestamp;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      status       <= res.status;
      session_out  <= res.session;
      allowed      <= res.allowed;
      owner_out    <= res_owner;
      expiry_cause <= res.cause;
      lock_changed <= res.lock_changed;
    end
  end

endmodule

### hdl/mli_cfg.sv
// ---------------------------------------------------------------------------
// mli_cfg
// configuration registers; lease length kept in microseconds
// ---------------------------------------------------------------------------
module mli_cfg
  import mli_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data,
  output logic [LEASE_US_BITS-1:0]   lease_us,
  output logic [FB_TIMEOUT_BITS-1:0] fb_timeout
);

  always_ff @(posedge clk) begin
    if (rst) begin
      lease_us   <= lease_to_us(LEASE_MS_RESET);
      fb_timeout <= FB_TIMEOUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_LEASE_MS: begin
          // scale to microseconds once, at write time
          lease_us <= lease_to_us(cfg_data[LEASE_MS_BITS-1:0]);
        end
        CFG_FB_TIMEOUT: begin
          fb_timeout <= cfg_data[FB_TIMEOUT_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### hdl/mli_core.sv
// ---------------------------------------------------------------------------
// mli_core
// lease state and the per-item decision logic
// ---------------------------------------------------------------------------
module mli_core
  import mli_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int OWNER_BITS = OWNER_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [KIND_BITS-1:0]       kind,
  input  logic [OWNER_BITS-1:0]      requester,
  input  logic [SESSION_BITS-1:0]    session_in,
  input  logic [SEQ_BITS-1:0]        sequence_in,
  input  logic [TIME_BITS-1:0]       timestamp,
  input  logic [LEASE_US_BITS-1:0]   lease_us,
  input  logic [FB_TIMEOUT_BITS-1:0] fb_timeout,
  output res_t                       res,
  output logic [OWNER_BITS-1:0]      res_owner
);

  logic [OWNER_BITS-1:0]   current_owner, current_owner_next;
  logic [SESSION_BITS-1:0] session_count, session_count_next;
  logic [SEQ_BITS-1:0]     last_sequence, last_sequence_next;
  logic [TIME_BITS-1:0]    lease_deadline, lease_deadline_next;
  logic [TIME_BITS-1:0]    feedback_time, feedback_time_next;
  logic                    feedback_seen, feedback_seen_next;

  logic [TIME_BITS:0]      dl_sum;
  logic [TIME_BITS-1:0]    new_deadline;
  logic [SESSION_BITS-1:0] session_inc;
  logic                    lease_over;
  logic                    fb_stale;
  logic                    renew_ok;

  // saturating deadline
  assign dl_sum       = {1'b0, timestamp} + (TIME_BITS+1)'(lease_us);
  assign new_deadline = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];

  // session counter skips zero on wrap
  assign session_inc  = (&session_count) ? SESSION_BITS'(1) : session_count + 1'b1;

  assign lease_over   = timestamp > lease_deadline;
  // a timestamp at or below the feedback time counts as age zero
  assign fb_stale     = !feedback_seen ||
                        ((timestamp > feedback_time) &&
                         ((timestamp - feedback_time) > TIME_BITS'(fb_timeout)));
  assign renew_ok     = (requester == current_owner) && (session_in == session_count) &&
                        !lease_over &&
                        ((sequence_in == '0) || (sequence_in > last_sequence));

  always_comb begin
    current_owner_next  = current_owner;
    session_count_next  = session_count;
    last_sequence_next  = last_sequence;
    lease_deadline_next = lease_deadline;
    feedback_time_next  = feedback_time;
    feedback_seen_next  = feedback_seen;
    res                 = '{status: STATUS_OK, session: '0, allowed: 1'b0,
                            cause: CAUSE_NONE, lock_changed: 1'b0};
    res_owner           = '0;

    case (kind_t'(kind))
      KIND_ACQUIRE: begin
        if (requester == '0) begin
          res.status = STATUS_BAD_ARG;
        end else if ((current_owner != '0) && (current_owner != requester)) begin
          res.status = STATUS_BAD_STATE;
        end else begin
          session_count_next  = session_inc;
          current_owner_next  = requester;
          last_sequence_next  = '0;
          lease_deadline_next = new_deadline;
          res.session         = session_inc;
        end
      end
      KIND_RENEW: begin
        if (!renew_ok) begin
          res.status = STATUS_BAD_STATE;
        end else begin
          if (sequence_in != '0) begin
            last_sequence_next = sequence_in;
          end
          lease_deadline_next = new_deadline;
        end
      end
      KIND_LOCK: begin
        res.lock_changed    = (current_owner != '0);
        current_owner_next  = '0;
        last_sequence_next  = '0;
        lease_deadline_next = '0;
      end
      KIND_FEEDBACK: begin
        feedback_time_next = timestamp;
        feedback_seen_next = 1'b1;
      end
      KIND_CHECK: begin
        if (current_owner != '0) begin
          if (lease_over || fb_stale) begin
            res.cause           = lease_over ? CAUSE_LEASE : CAUSE_FEEDBACK;
            current_owner_next  = '0;
            last_sequence_next  = '0;
            lease_deadline_next = '0;
          end else begin
            res.allowed = 1'b1;
            res_owner   = current_owner;
          end
        end
      end
      default: begin
        res.status = STATUS_BAD_ARG;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_owner  <= '0;
      session_count  <= '0;
      last_sequence  <= '0;
      lease_deadline <= '0;
      feedback_time  <= '0;
      feedback_seen  <= 1'b0;
    end else if (advance) begin
      current_owner  <= current_owner_next;
      session_count  <= session_count_next;
      last_sequence  <= last_sequence_next;
      lease_deadline <= lease_deadline_next;
      feedback_time  <= feedback_time_next;
      feedback_seen  <= feedback_seen_next;
    end
  end

endmodule

### hdl/mli_checker.sv
// ---------------------------------------------------------------------------
// mli_checker
// port-level checks on the interlock results, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mli_checker
  import mli_pkg::*;
#(
  parameter int OWNER_BITS = OWNER_BITS_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [1:0]              status,
  input logic [SESSION_BITS-1:0] session_out,
  input logic                    allowed,
  input logic [OWNER_BITS-1:0]   owner_out,
  input logic [1:0]              expiry_cause,
  input logic                    lock_changed
);

  // a grant names a real owner and carries no cause
  `MLI_ASSERT(a_grant_owner, out_valid && allowed |-> owner_out != '0 && expiry_cause == CAUSE_NONE && status == STATUS_OK)

  // a granted session is nonzero only on a clean acquire
  `MLI_ASSERT(a_session_clean, out_valid && session_out != '0 |-> status == STATUS_OK && !allowed && !lock_changed && expiry_cause == CAUSE_NONE)

  // a stalled result holds
  `MLI_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(session_out) && $stable(owner_out))

  // nothing is shown straight after reset
  `MLI_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid)

endmodule

bind motion_lease_interlock mli_checker #(
  .OWNER_BITS (OWNER_BITS)
) u_mli_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .session_out  (session_out),
  .allowed      (allowed),
  .owner_out    (owner_out),
  .expiry_cause (expiry_cause),
  .lock_changed (lock_changed)
);
